[hw/rtl/dlr_pkg.sv]
// dlr_pkg: shared widths, constants, function codes and the divider request
// type for the DDA line rasterizer. No dependencies.
package dlr_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int FRAC_BITS     = 16;

    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 16;

    // Quotient holds one integer bit plus the fraction; the step adds a sign.
    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int XACC_W = X_W + FRAC_BITS;
    localparam int YACC_W = Y_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef struct packed {
        logic           start;
        logic [X_W-1:0] mag;
        logic [X_W-1:0] divisor;
    } div_req_t;

endpackage

[hw/rtl/dlr_div.sv]
// dlr_div: iterative unsigned divider, floor((mag << FRAC_BITS) / divisor),
// one quotient bit per cycle. Requires mag <= divisor. Depends on dlr_pkg.
module dlr_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dlr_pkg::div_req_t        req,
    output logic                     done,
    output logic [dlr_pkg::QUO_W-1:0] quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [dlr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [dlr_pkg::X_W-1:0]         rem_reg, rem_next;
    logic [dlr_pkg::X_W-1:0]         div_reg, div_next;
    logic [dlr_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic [dlr_pkg::X_W:0]           trial;
    logic                            fits;

    always_comb
    begin
        // First bit is the integer bit: compare the remainder unshifted.
        trial = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fits  = (trial >= {1'b0, div_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.mag;
            div_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? dlr_pkg::X_W'(trial - {1'b0, div_reg})
                            : dlr_pkg::X_W'(trial);
            quo_next = {quo_reg[dlr_pkg::QUO_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dlr_pkg::CNT_W'(dlr_pkg::FRAC_BITS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[hw/rtl/dda_line_rasterizer_top.sv]
// dda_line_rasterizer_top: DDA line rasterizer with a shared iterative divider
// for the load setup. Depends on dlr_pkg and dlr_div.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | func, start_x, start_y, end_x, end_y,
//          |                      | line_color
//  out     | out_valid / out_ready| pixel_x, pixel_y, pixel_addr, pixel_color,
//          |                      | last_pixel
//
// With out_ready held high, advances flow one per cycle. A load of a line
// with nonzero length runs two divisions, x then y, on the one shared
// divider, and in_ready stays low after the load transfer until the y
// division is done. A zero-length load starts no division. Reset (rst_n,
// asynchronous) drops any active line and empties the output register. A
// stalled result holds in the output register; in_ready is low while it
// waits and out_ready is low.
module dda_line_rasterizer_top
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [dlr_pkg::X_W-1:0]        start_x,
    input  logic [dlr_pkg::Y_W-1:0]        start_y,
    input  logic [dlr_pkg::X_W-1:0]        end_x,
    input  logic [dlr_pkg::Y_W-1:0]        end_y,
    input  logic [dlr_pkg::COLOR_W-1:0]    line_color,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dlr_pkg::X_W-1:0]        pixel_x,
    output logic [dlr_pkg::Y_W-1:0]        pixel_y,
    output logic [dlr_pkg::ADDR_W-1:0]     pixel_addr,
    output logic [dlr_pkg::COLOR_W-1:0]    pixel_color,
    output logic                           last_pixel
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIVX = 2'd1;
    localparam logic [1:0] ST_DIVY = 2'd2;

    localparam int AFULL_W = dlr_pkg::ADDR_W + 2;

    // Sequencer and line state
    logic [1:0]                        state_reg, state_next;
    logic                              line_active_reg, line_active_next;
    logic [dlr_pkg::XACC_W-1:0]        x_accum_reg, x_accum_next;
    logic [dlr_pkg::YACC_W-1:0]        y_accum_reg, y_accum_next;
    logic [dlr_pkg::STEP_W-1:0]        x_step_reg, x_step_next;
    logic [dlr_pkg::STEP_W-1:0]        y_step_reg, y_step_next;
    logic [dlr_pkg::X_W-1:0]           pixels_left_reg, pixels_left_next;
    logic [dlr_pkg::COLOR_W-1:0]       color_reg, color_next;
    logic [dlr_pkg::Y_W-1:0]           ady_reg, ady_next;
    logic                              neg_x_reg, neg_x_next;
    logic                              neg_y_reg, neg_y_next;

    // Output register
    logic                              out_valid_reg, out_valid_next;
    logic [dlr_pkg::X_W-1:0]           px_reg, px_next;
    logic [dlr_pkg::Y_W-1:0]           py_reg, py_next;
    logic [dlr_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [dlr_pkg::COLOR_W-1:0]       pcolor_reg, pcolor_next;
    logic                              last_reg, last_next;

    // Load setup and divider hookup
    logic                              in_xfer;
    logic signed [dlr_pkg::X_W:0]      dx;
    logic signed [dlr_pkg::Y_W:0]      dy;
    logic [dlr_pkg::X_W-1:0]           adx;
    logic [dlr_pkg::Y_W-1:0]           ady;
    logic [dlr_pkg::X_W-1:0]           load_steps;
    dlr_pkg::div_req_t                 div_req;
    logic                              div_done;
    logic [dlr_pkg::QUO_W-1:0]         div_quo;
    logic [dlr_pkg::STEP_W-1:0]        quo_ext;
    logic [dlr_pkg::X_W-1:0]           cur_x;
    logic [dlr_pkg::Y_W-1:0]           cur_y;
    logic [AFULL_W-1:0]                addr_full;
    logic                              is_last;

    dlr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Accept only while the sequencer is idle and the output slot can take a pixel.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
        dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
        adx = dx[dlr_pkg::X_W] ? dlr_pkg::X_W'(-dx) : dlr_pkg::X_W'(dx);
        ady = dy[dlr_pkg::Y_W] ? dlr_pkg::Y_W'(-dy) : dlr_pkg::Y_W'(dy);
        load_steps = (adx > dlr_pkg::X_W'(ady)) ? adx : dlr_pkg::X_W'(ady);

        quo_ext = dlr_pkg::STEP_W'(div_quo);

        // Pixel position is the integer part of each accumulator.
        cur_x     = x_accum_reg[dlr_pkg::XACC_W-1 -: dlr_pkg::X_W];
        cur_y     = y_accum_reg[dlr_pkg::YACC_W-1 -: dlr_pkg::Y_W];
        addr_full = AFULL_W'(cur_y) * AFULL_W'(dlr_pkg::SCREEN_WIDTH) + AFULL_W'(cur_x);
        is_last   = (pixels_left_reg == '0);
    end

    always_comb
    begin
        state_next       = state_reg;
        line_active_next = line_active_reg;
        x_accum_next     = x_accum_reg;
        y_accum_next     = y_accum_reg;
        x_step_next      = x_step_reg;
        y_step_next      = y_step_reg;
        pixels_left_next = pixels_left_reg;
        color_next       = color_reg;
        ady_next         = ady_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        px_next          = px_reg;
        py_next          = py_reg;
        addr_next        = addr_reg;
        pcolor_next      = pcolor_reg;
        last_next        = last_reg;

        div_req.start    = 1'b0;
        div_req.mag      = adx;
        div_req.divisor  = load_steps;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && func == dlr_pkg::FUNC_LOAD)
                begin
                    // Restart the line: drop whatever was active.
                    line_active_next = 1'b1;
                    x_accum_next     = {start_x, {dlr_pkg::FRAC_BITS{1'b0}}};
                    y_accum_next     = {start_y, {dlr_pkg::FRAC_BITS{1'b0}}};
                    x_step_next      = '0;
                    y_step_next      = '0;
                    pixels_left_next = load_steps;
                    color_next       = line_color;
                    ady_next         = ady;
                    neg_x_next       = dx[dlr_pkg::X_W];
                    neg_y_next       = dy[dlr_pkg::Y_W];
                    if (load_steps != '0)
                    begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIVX;
                    end
                end
                else if (in_xfer && line_active_reg)
                begin
                    // Emit the current pixel, then advance or end the line.
                    out_valid_next = 1'b1;
                    px_next        = cur_x;
                    py_next        = cur_y;
                    addr_next      = addr_full[dlr_pkg::ADDR_W-1:0];
                    pcolor_next    = color_reg;
                    last_next      = is_last;
                    if (is_last)
                    begin
                        line_active_next = 1'b0;
                    end
                    else
                    begin
                        x_accum_next = x_accum_reg +
                            {{(dlr_pkg::XACC_W-dlr_pkg::STEP_W){x_step_reg[dlr_pkg::STEP_W-1]}},
                             x_step_reg};
                        y_accum_next = y_accum_reg +
                            {{(dlr_pkg::YACC_W-dlr_pkg::STEP_W){y_step_reg[dlr_pkg::STEP_W-1]}},
                             y_step_reg};
                        pixels_left_next = pixels_left_reg - 1'b1;
                    end
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    x_step_next     = neg_x_reg ? -quo_ext : quo_ext;
                    // Hand the divider the y magnitude over the same step count.
                    div_req.start   = 1'b1;
                    div_req.mag     = dlr_pkg::X_W'(ady_reg);
                    div_req.divisor = pixels_left_reg;
                    state_next      = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    y_step_next = neg_y_reg ? -quo_ext : quo_ext;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_accum_reg     <= x_accum_next;
        y_accum_reg     <= y_accum_next;
        x_step_reg      <= x_step_next;
        y_step_reg      <= y_step_next;
        pixels_left_reg <= pixels_left_next;
        color_reg       <= color_next;
        ady_reg         <= ady_next;
        neg_x_reg       <= neg_x_next;
        neg_y_reg       <= neg_y_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        addr_reg        <= addr_next;
        pcolor_reg      <= pcolor_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_addr  = addr_reg;
    assign pixel_color = pcolor_reg;
    assign last_pixel  = last_reg;

    // The divider reports completion only while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVX || state_reg == ST_DIVY))
        else $error("divider done outside a division state");

    // A load of nonzero length starts the x division.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && func == dlr_pkg::FUNC_LOAD && load_steps != '0)
            |=> (state_reg == ST_DIVX))
        else $error("load did not start the divider");

    // Emitting the final pixel ends the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && func == dlr_pkg::FUNC_ADVANCE && line_active_reg && is_last)
            |=> (!line_active_reg && out_valid_reg && last_reg))
        else $error("final pixel did not end the line");

    // No input transfer while a division is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted during load setup");

endmodule
